### src/scale_coordinate_mapper_top_macros.svh
// Assertion macros for the scale coordinate mapper RTL
`ifndef SCALE_COORDINATE_MAPPER_TOP_MACROS_SVH
`define SCALE_COORDINATE_MAPPER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scm assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define SCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scm assertion failed");

`endif

### src/scm_pkg.sv
// Shared constants and types for the scale coordinate mapper
package scm_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_IDX_BITS   = 3;
  localparam int NUM_LANES      = 4;

  // divider lanes: start and end numerators per axis
  localparam int LANE_X0 = 0;
  localparam int LANE_X1 = 1;
  localparam int LANE_Y0 = 2;
  localparam int LANE_Y1 = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_SCR_WIDTH  = 3'd2,
    CFG_SCR_HEIGHT = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic in_range;
  } stage_ctl_t;

endpackage

### src/scm_if.sv
// Channel interfaces: coordinate input, mapped result output, register writes
interface scm_in_if #(
  parameter int CB = scm_pkg::COORD_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [CB-1:0] src_x;
  logic [CB-1:0] src_y;

  modport source (output valid, output src_x, output src_y, input ready);
  modport sink   (input valid, input src_x, input src_y, output ready);
endinterface

interface scm_out_if #(
  parameter int CB = scm_pkg::COORD_BITS_DEF
);
  logic        valid;
  logic        ready;
  logic [CB:0] screen_x;
  logic [CB:0] screen_y;
  logic [CB:0] span_width;
  logic [CB:0] span_height;

  modport source (output valid, output screen_x, output screen_y,
                  output span_width, output span_height, input ready);
  modport sink   (input valid, input screen_x, input screen_y,
                  input span_width, input span_height, output ready);
endinterface

interface scm_cfg_if #(
  parameter int CB = scm_pkg::COORD_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic [scm_pkg::CFG_IDX_BITS-1:0]     index;
  logic [CB:0]                          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/scale_coordinate_mapper_top.sv
// Throughput: one coordinate per cycle unless out_o stalls; entry stage,
//   COORD_BITS+1 divider cells, output register, each stage with its own valid so
//   bubbles collapse under backpressure.
// Quotient bits come one per cell, so the cell count sets the latency.
// Reset: rst_ni async active low clears all stage valids and the four size registers.
module scale_coordinate_mapper_top #(
  parameter int COORD_BITS = scm_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scm_cfg_if.sink     cfg_i,
  scm_in_if.sink      in_i,
  scm_out_if.source   out_o
);
  import scm_pkg::*;

  `include "scale_coordinate_mapper_top_macros.svh"

  localparam int CB = COORD_BITS;
  localparam int QW = CB + 1;
  localparam int WW = 2 * CB + 2;

  logic [CB:0] src_width_q, src_height_q, scr_width_q, scr_height_q;

  stage_ctl_t                    ctl   [QW+1];
  logic [NUM_LANES-1:0][WW-1:0]  word  [QW+1];
  logic                          rdy   [QW+1];
  logic                          post_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= '0;
      src_height_q <= '0;
      scr_width_q  <= '0;
      scr_height_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SRC_WIDTH:  src_width_q  <= cfg_i.data;
        CFG_SRC_HEIGHT: src_height_q <= cfg_i.data;
        CFG_SCR_WIDTH:  scr_width_q  <= cfg_i.data;
        CFG_SCR_HEIGHT: scr_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  scm_prep #(.CB(CB)) u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .src_x_i      (in_i.src_x),
    .src_y_i      (in_i.src_y),
    .src_width_i  (src_width_q),
    .src_height_i (src_height_q),
    .scr_width_i  (scr_width_q),
    .scr_height_i (scr_height_q),
    .ready_i      (rdy[0]),
    .ctl_o        (ctl[0]),
    .word_o       (word[0])
  );

  for (genvar g = 0; g < QW; g++) begin : g_cell
    scm_div_cell #(.CB(CB)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .div_x_i (src_width_q),
      .div_y_i (src_height_q),
      .ctl_i   (ctl[g]),
      .word_i  (word[g]),
      .ready_o (rdy[g]),
      .ctl_o   (ctl[g+1]),
      .word_o  (word[g+1]),
      .ready_i (rdy[g+1])
    );
  end

  assign rdy[QW] = post_ready;

  scm_post #(.CB(CB)) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl[QW]),
    .word_i  (word[QW]),
    .ready_o (post_ready),
    .out_o   (out_o)
  );

  // input side only backs up when every stage is full and the result is stalled
  `SCM_ASSERT_NOW(a_backpressure_full, !in_i.ready, out_o.valid && !out_o.ready)
  // an out-of-range beat leaving the last cell comes out as all zeros
  `SCM_ASSERT_NEXT(a_out_of_range_zero,
    ctl[QW].valid && !ctl[QW].in_range && post_ready,
    out_o.screen_x == '0 && out_o.screen_y == '0 &&
    out_o.span_width == '0 && out_o.span_height == '0)
  // a source width write lands in its register
  `SCM_ASSERT_NEXT(a_cfg_src_width, cfg_i.valid && cfg_i.index == CFG_SRC_WIDTH,
    src_width_q == $past(cfg_i.data))
  // a full entry stage holds its numerators while the first cell is stalled
  `SCM_ASSERT_NEXT(a_prep_hold, ctl[0].valid && !rdy[0], $stable(word[0]))

endmodule

### src/scm_prep.sv
// Entry stage: range check and numerator products for the divider lanes
module scm_prep #(
  parameter int CB = scm_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  output logic                                       ready_o,
  input  logic [CB-1:0]                              src_x_i,
  input  logic [CB-1:0]                              src_y_i,
  input  logic [CB:0]                                src_width_i,
  input  logic [CB:0]                                src_height_i,
  input  logic [CB:0]                                scr_width_i,
  input  logic [CB:0]                                scr_height_i,
  input  logic                                       ready_i,
  output scm_pkg::stage_ctl_t                        ctl_o,
  output logic [scm_pkg::NUM_LANES-1:0][2*CB+1:0]    word_o
);
  import scm_pkg::*;

  localparam int WW = 2 * CB + 2;
  localparam int PW = 2 * CB + 1;

  stage_ctl_t                    ctl_q, ctl_d;
  logic [NUM_LANES-1:0][WW-1:0]  word_q, word_d;
  logic [2*CB:0]                 prod_x, prod_y;
  logic                          adv;

  assign adv     = !ctl_q.valid || ready_i;
  assign ready_o = adv;

  assign prod_x = PW'(src_x_i) * PW'(scr_width_i);
  assign prod_y = PW'(src_y_i) * PW'(scr_height_i);

  always_comb begin
    ctl_d.valid    = valid_i;
    ctl_d.in_range = ({1'b0, src_x_i} < src_width_i) && ({1'b0, src_y_i} < src_height_i);
    word_d[LANE_X0] = WW'(prod_x);
    word_d[LANE_X1] = WW'(prod_x) + WW'(scr_width_i);
    word_d[LANE_Y0] = WW'(prod_y);
    word_d[LANE_Y1] = WW'(prod_y) + WW'(scr_height_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      word_q <= word_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign word_o = word_q;

endmodule

### src/scm_div_cell.sv
// Divider cell: one restoring-division quotient bit for each of the four lanes
module scm_div_cell #(
  parameter int CB = scm_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic [CB:0]                                div_x_i,
  input  logic [CB:0]                                div_y_i,
  input  scm_pkg::stage_ctl_t                        ctl_i,
  input  logic [scm_pkg::NUM_LANES-1:0][2*CB+1:0]    word_i,
  output logic                                       ready_o,
  output scm_pkg::stage_ctl_t                        ctl_o,
  output logic [scm_pkg::NUM_LANES-1:0][2*CB+1:0]    word_o,
  input  logic                                       ready_i
);
  import scm_pkg::*;

  localparam int DW = CB + 1;
  localparam int QW = CB + 1;
  localparam int WW = DW + QW;

  stage_ctl_t                    ctl_q;
  logic [NUM_LANES-1:0][WW-1:0]  word_q, word_d;
  logic                          adv;

  assign adv     = !ctl_q.valid || ready_i;
  assign ready_o = adv;

  // word = {partial remainder, numerator bits left / quotient bits so far}
  always_comb begin
    logic [DW:0]   trial;
    logic [DW-1:0] dvs;
    for (int l = 0; l < NUM_LANES; l++) begin
      dvs   = (l == LANE_X0 || l == LANE_X1) ? div_x_i : div_y_i;
      trial = {word_i[l][WW-1:QW], word_i[l][QW-1]};
      if (trial >= {1'b0, dvs}) begin
        trial = trial - {1'b0, dvs};
        word_d[l] = {trial[DW-1:0], word_i[l][QW-2:0], 1'b1};
      end else begin
        word_d[l] = {trial[DW-1:0], word_i[l][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && ctl_i.valid) begin
      word_q <= word_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign word_o = word_q;

endmodule

### src/scm_post.sv
// Output stage: spans from quotient pairs, out-of-range zeroing, result register
module scm_post #(
  parameter int CB = scm_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  scm_pkg::stage_ctl_t                        ctl_i,
  input  logic [scm_pkg::NUM_LANES-1:0][2*CB+1:0]    word_i,
  output logic                                       ready_o,
  scm_out_if.source                                  out_o
);
  import scm_pkg::*;

  localparam int QW = CB + 1;

  logic          valid_q;
  logic [QW-1:0] sx_q, sy_q, sw_q, sh_q;
  logic [QW-1:0] sx_d, sy_d, sw_d, sh_d;
  logic          adv;

  assign adv     = !valid_q || out_o.ready;
  assign ready_o = adv;

  always_comb begin
    if (ctl_i.in_range) begin
      sx_d = word_i[LANE_X0][QW-1:0];
      sy_d = word_i[LANE_Y0][QW-1:0];
      sw_d = word_i[LANE_X1][QW-1:0] - word_i[LANE_X0][QW-1:0];
      sh_d = word_i[LANE_Y1][QW-1:0] - word_i[LANE_Y0][QW-1:0];
    end else begin
      sx_d = '0;
      sy_d = '0;
      sw_d = '0;
      sh_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && ctl_i.valid) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      sw_q <= sw_d;
      sh_q <= sh_d;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.screen_x    = sx_q;
  assign out_o.screen_y    = sy_q;
  assign out_o.span_width  = sw_q;
  assign out_o.span_height = sh_q;

endmodule

### tb/sv/scale_coordinate_mapper_top_tb.sv
// Self-checking testbench for scale_coordinate_mapper_top: random sizes, coordinates and stalls
`timescale 1ns / 1ps

module scale_coordinate_mapper_top_tb;
  import scm_pkg::*;

  localparam int CB         = COORD_BITS_DEF;
  localparam int LATENCY    = CB + 3;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 107;
  localparam int MAX_COORD  = (1 << CB) - 1;
  localparam int MAX_SIZE   = (1 << (CB + 1)) - 1;

  typedef struct packed {
    logic [CB:0] screen_x;
    logic [CB:0] screen_y;
    logic [CB:0] span_width;
    logic [CB:0] span_height;
  } span_t;

  class coord_map_scoreboard;
    logic [CB:0] src_w, src_h, scr_w, scr_h;
    span_t       expected_spans[$];
    int unsigned mismatches;

    function new();
      src_w = '0;
      src_h = '0;
      scr_w = '0;
      scr_h = '0;
      mismatches = 0;
    endfunction

    function void write_size(logic [CFG_IDX_BITS-1:0] idx, logic [CB:0] data);
      case (idx)
        CFG_SRC_WIDTH:  src_w = data;
        CFG_SRC_HEIGHT: src_h = data;
        CFG_SCR_WIDTH:  scr_w = data;
        CFG_SCR_HEIGHT: scr_h = data;
        default: ;
      endcase
    endfunction

    // first screen pixel and span for one source position on one axis
    function void map_axis(input logic [CB-1:0] pos, input logic [CB:0] src,
                           input logic [CB:0] scr, output logic [CB:0] first,
                           output logic [CB:0] len);
      longint unsigned lo, hi;
      lo = (longint'(pos) * longint'(scr)) / longint'(src);
      hi = ((longint'(pos) + 1) * longint'(scr)) / longint'(src);
      first = lo[CB:0];
      len = hi[CB:0] - lo[CB:0];
    endfunction

    function void note_coord(logic [CB-1:0] x, logic [CB-1:0] y);
      span_t e;
      e = '0;
      if ({1'b0, x} < src_w && {1'b0, y} < src_h) begin
        map_axis(x, src_w, scr_w, e.screen_x, e.span_width);
        map_axis(y, src_h, scr_h, e.screen_y, e.span_height);
      end
      expected_spans.push_back(e);
    endfunction

    function void compare_field(string name, logic [CB:0] want, logic [CB:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_span(span_t got);
      span_t e;
      if (expected_spans.size() == 0) begin
        $error("result beat with no coordinate outstanding");
        mismatches++;
      end else begin
        e = expected_spans.pop_front();
        compare_field("screen_x", e.screen_x, got.screen_x);
        compare_field("screen_y", e.screen_y, got.screen_y);
        compare_field("span_width", e.span_width, got.span_width);
        compare_field("span_height", e.span_height, got.span_height);
      end
    endfunction

    function int unsigned outstanding();
      return expected_spans.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  scm_cfg_if #(.CB(CB)) size_if();
  scm_in_if  #(.CB(CB)) coord_if();
  scm_out_if #(.CB(CB)) span_if();

  scale_coordinate_mapper_top #(.COORD_BITS(CB)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (size_if),
    .in_i   (coord_if),
    .out_o  (span_if)
  );

  coord_map_scoreboard sb = new();

  int unsigned coord_burst, span_burst, size_burst, idle_cycles;

  always #1 clk_i = ~clk_i;

  // random gap before each beat, with occasional runs of back-to-back beats
  function automatic int unsigned pick_gap(inout int unsigned burst);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [CB:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return (CB+1)'(1);
      2: return (CB+1)'(1 << CB);
      3: return (CB+1)'(MAX_SIZE);
      4, 5: return (CB+1)'($urandom_range(1, 16));
      6, 7: return (CB+1)'($urandom_range(1, 1 << CB));
      default: return (CB+1)'($urandom_range(1, MAX_SIZE));
    endcase
  endfunction

  // mostly inside the source, some just past the edge, some anywhere
  function automatic logic [CB-1:0] pick_coord(logic [CB:0] limit);
    int unsigned r, top;
    r = $urandom_range(0, 99);
    top = (limit > MAX_COORD) ? MAX_COORD : int'(limit) - 1;
    if (limit != 0 && r < 80) return CB'($urandom_range(0, top));
    if (limit <= MAX_COORD && r < 88) return limit[CB-1:0];
    return CB'($urandom_range(0, MAX_COORD));
  endfunction

  task automatic send_coord(input logic [CB-1:0] x, input logic [CB-1:0] y);
    int unsigned gap;
    gap = pick_gap(coord_burst);
    if (gap != 0) begin
      coord_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    coord_if.valid <= 1'b1;
    coord_if.src_x <= x;
    coord_if.src_y <= y;
    do @(posedge clk_i); while (!(coord_if.valid && coord_if.ready));
    @(negedge clk_i);
  endtask

  task automatic write_size_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CB:0] data);
    int unsigned gap;
    gap = pick_gap(size_burst);
    if (gap != 0) begin
      size_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    size_if.valid <= 1'b1;
    size_if.index <= idx;
    size_if.data <= data;
    do @(posedge clk_i); while (!(size_if.valid && size_if.ready));
    @(negedge clk_i);
  endtask

  // drain the pipe, then load all four sizes; junk adds a write to an unused index
  task automatic set_sizes(input logic [CB:0] sw, input logic [CB:0] sh,
                           input logic [CB:0] cw, input logic [CB:0] ch, input bit junk);
    coord_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    write_size_reg(CFG_SRC_WIDTH, sw);
    write_size_reg(CFG_SRC_HEIGHT, sh);
    write_size_reg(CFG_SCR_WIDTH, cw);
    write_size_reg(CFG_SCR_HEIGHT, ch);
    if (junk)
      write_size_reg(
        CFG_IDX_BITS'($urandom_range(int'(CFG_SCR_HEIGHT) + 1, (1 << CFG_IDX_BITS) - 1)),
        (CB+1)'($urandom_range(0, MAX_SIZE)));
    size_if.valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (size_if.valid && size_if.ready)
        sb.write_size(size_if.index, size_if.data);
      if (coord_if.valid && coord_if.ready)
        sb.note_coord(coord_if.src_x, coord_if.src_y);
      if (span_if.valid && span_if.ready)
        sb.check_span({span_if.screen_x, span_if.screen_y,
                       span_if.span_width, span_if.span_height});
    end
  end

  always @(posedge clk_i) begin
    if ((size_if.valid && size_if.ready) || (coord_if.valid && coord_if.ready) ||
        (span_if.valid && span_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("scale_coordinate_mapper_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side backpressure
  initial begin
    span_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      int unsigned gap;
      gap = pick_gap(span_burst);
      if (gap != 0) begin
        span_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      span_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(span_if.valid && span_if.ready));
      @(negedge clk_i);
    end
  end

  initial begin
    logic [CB:0] sw, sh, cw, ch;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    idle_cycles = 0;
    coord_burst = 0;
    span_burst = 0;
    size_burst = 0;
    coord_if.valid = 1'b0;
    coord_if.src_x = '0;
    coord_if.src_y = '0;
    size_if.valid = 1'b0;
    size_if.index = CFG_SRC_WIDTH;
    size_if.data = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sizes still at reset: everything maps to zero
    send_coord(0, 0);
    send_coord(CB'(MAX_COORD), CB'(MAX_COORD));

    set_sizes((CB+1)'(1 << CB), (CB+1)'(1 << CB), (CB+1)'(1 << CB), (CB+1)'(1 << CB), 1'b0);
    send_coord(0, 0);
    send_coord(CB'(MAX_COORD), CB'(MAX_COORD));
    send_coord(CB'(1 << (CB - 1)), 1);

    set_sizes((CB+1)'(1 << CB), (CB+1)'(1 << CB), (CB+1)'(MAX_SIZE), (CB+1)'(MAX_SIZE), 1'b0);
    send_coord(CB'(MAX_COORD), CB'(MAX_COORD));
    send_coord(0, CB'(MAX_COORD));

    // strong upscale, then coordinates one past the source edge
    set_sizes(3, 1, (CB+1)'(1 << CB), (CB+1)'(1 << CB), 1'b0);
    send_coord(0, 0);
    send_coord(1, 0);
    send_coord(2, 0);
    send_coord(3, 0);
    send_coord(0, 1);

    // sizes above 4096 and a full downscale
    set_sizes((CB+1)'(MAX_SIZE), (CB+1)'(MAX_SIZE), 1, 1, 1'b0);
    send_coord(CB'(MAX_COORD), CB'(MAX_COORD));
    send_coord(0, 0);

    // zero screen size
    set_sizes(10, 10, 0, 0, 1'b0);
    send_coord(5, 5);
    send_coord(9, 9);

    // writes to unused indexes change nothing
    set_sizes(7, 5, 100, 100, 1'b1);
    send_coord(6, 4);
    send_coord(7, 4);

    // zero source width
    set_sizes(0, 10, 100, 100, 1'b0);
    send_coord(0, 0);

    for (int p = 0; p < PHASES; p++) begin
      sw = pick_size();
      sh = pick_size();
      cw = pick_size();
      ch = pick_size();
      set_sizes(sw, sh, cw, ch, $urandom_range(0, 2) == 0);
      repeat (PHASE_LEN) send_coord(pick_coord(sw), pick_coord(sh));
    end

    coord_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("scale_coordinate_mapper_top regression: pass");
    else
      $display("scale_coordinate_mapper_top regression: fail");
    $finish;
  end

endmodule
